/* rtl/json_token_lexer_assert.svh */
// ---------------------------------------------------------------------------
// JSON token lexer assertion macros
// Shared concurrent assertion forms for the lexer checker.
// ---------------------------------------------------------------------------
`ifndef JSON_TOKEN_LEXER_ASSERT_SVH
`define JSON_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define JTL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define JTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/jtl_pkg.sv */
// ---------------------------------------------------------------------------
// JSON token lexer package
// Token, error and action codes, queue sizes, character constants and the result item type.
// ---------------------------------------------------------------------------
package jtl_pkg;

   localparam int POSITION_BITS = 24;
   localparam int POS_OUT_BITS  = 24;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;

   // token kinds
   localparam logic [3:0] KIND_TEXT     = 4'd0;
   localparam logic [3:0] KIND_INT      = 4'd1;
   localparam logic [3:0] KIND_FLOAT    = 4'd2;
   localparam logic [3:0] KIND_STRING   = 4'd3;
   localparam logic [3:0] KIND_TRUE     = 4'd4;
   localparam logic [3:0] KIND_FALSE    = 4'd5;
   localparam logic [3:0] KIND_NULL     = 4'd6;
   localparam logic [3:0] KIND_LBRACE   = 4'd7;
   localparam logic [3:0] KIND_RBRACE   = 4'd8;
   localparam logic [3:0] KIND_LBRACKET = 4'd9;
   localparam logic [3:0] KIND_RBRACKET = 4'd10;
   localparam logic [3:0] KIND_COLON    = 4'd11;
   localparam logic [3:0] KIND_COMMA    = 4'd12;
   localparam logic [3:0] KIND_END      = 4'd13;
   localparam logic [3:0] KIND_ERROR    = 4'd14;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_NUMBER     = 3'd1;
   localparam logic [2:0] ERR_LINE_END   = 3'd2;
   localparam logic [2:0] ERR_IDENT      = 3'd3;
   localparam logic [2:0] ERR_ILLEGAL_CH = 3'd4;

   // input actions
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // characters
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_VT       = 8'h0B;
   localparam logic [7:0] CH_FF       = 8'h0C;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_T        = 8'h74;
   localparam logic [7:0] CH_F        = 8'h66;
   localparam logic [7:0] CH_N        = 8'h6E;

   localparam logic [7:0] KW_TRUE  [4] = '{8'h74, 8'h72, 8'h75, 8'h65};
   localparam logic [7:0] KW_FALSE [5] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};
   localparam logic [7:0] KW_NULL  [4] = '{8'h6E, 8'h75, 8'h6C, 8'h6C};

   typedef struct packed {
      logic [3:0]              token_kind;
      logic [7:0]              text_byte;
      logic [2:0]              error_code;
      logic [POS_OUT_BITS-1:0] position;
      logic                    last_result;
   } rsp_type;

endpackage

/* rtl/json_token_lexer.sv */
// ---------------------------------------------------------------------------
// JSON token lexer
// Streams JSON text bytes in and token events out.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one item per byte (req_action = 0, byte on req_char_byte)
//   or an end-of-input item (req_action = 1). rsp channel: token events,
//   with rsp_last_result set on the final event caused by an input item.
//   An item may cause no event (whitespace, bytes after an error, quotes
//   that open a string), one, or two (a terminator that ends a number or
//   keyword and itself yields an event, or a pending token before the end).
// Output: events are registered in the result queue before they appear on rsp.
// Throughput: one item per cycle while items average at most one event and
//   rsp_ready is high; an item with two events needs two rsp transfers. Events
//   go into a four-entry queue; req_ready is high while two or more slots are free.
// Reset: synchronous; lexer state, byte offset and the queue are cleared.
// Stall: while rsp_ready is low the head event holds; input carries on
//   until the queue has fewer than two free slots.
// ---------------------------------------------------------------------------
module json_token_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [7:0]  rsp_text_byte,
   output logic [2:0]  rsp_error_code,
   output logic [23:0] rsp_position,
   output logic        rsp_last_result
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_STR,
      MODE_WORD,
      MODE_ERR
   } mode_type;

   mode_type                          mode_ff, mode_in;
   logic                              dot_ff, dot_in;
   logic                              prev_digit_ff, prev_digit_in;
   logic [2:0]                        wlen_ff, wlen_in;
   logic [2:0]                        cand_ff, cand_in;
   logic [jtl_pkg::POSITION_BITS-1:0] offset_ff, offset_in;

   jtl_pkg::rsp_type                  fifo_ff [jtl_pkg::FIFO_DEPTH];
   logic [jtl_pkg::FIFO_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [jtl_pkg::FIFO_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [jtl_pkg::FIFO_CW-1:0]       count_ff, count_in;

   logic                              accept, pop;
   logic [7:0]                        c;
   logic                              c_digit, c_lower, c_space;
   logic [jtl_pkg::POS_OUT_BITS-1:0]  pos_now;

   // idle decode of the current byte
   logic                              id_v, id_start, id_digit;
   mode_type                          id_mode;
   logic [2:0]                        id_wlen, id_cand;
   jtl_pkg::rsp_type                  id_res;

   // keyword completion
   logic                              wk_legal;
   logic [3:0]                        wk_kind;

   logic                              use_idle, idle_slot1;
   logic                              r0_v, r1_v;
   jtl_pkg::rsp_type                  r0, r1, r0_q, r1_q;
   logic [1:0]                        push_n;

   assign accept  = req_valid && req_ready;
   assign pop     = rsp_valid && rsp_ready;
   assign c       = req_char_byte;
   assign c_digit = (c >= 8'h30) && (c <= 8'h39);
   assign c_lower = (c >= 8'h61) && (c <= 8'h7A);
   assign c_space = (c == jtl_pkg::CH_SPACE) || (c == jtl_pkg::CH_TAB) ||
                    (c == jtl_pkg::CH_LF) || (c == jtl_pkg::CH_VT) ||
                    (c == jtl_pkg::CH_FF) || (c == jtl_pkg::CH_CR);
   assign pos_now = jtl_pkg::POS_OUT_BITS'(offset_ff);

   // what an idle lexer does with this byte
   always_comb begin
      id_v     = 1'b0;
      id_start = 1'b0;
      id_digit = 1'b0;
      id_mode  = MODE_IDLE;
      id_wlen  = 3'd0;
      id_cand  = 3'b111;
      id_res.token_kind  = jtl_pkg::KIND_TEXT;
      id_res.text_byte   = 8'd0;
      id_res.error_code  = jtl_pkg::ERR_NONE;
      id_res.position    = pos_now;
      id_res.last_result = 1'b0;
      priority if (c_space) begin
         id_mode = MODE_IDLE;
      end else if (c_digit || (c == jtl_pkg::CH_MINUS)) begin
         id_start         = 1'b1;
         id_mode          = MODE_NUM;
         id_digit         = c_digit;
         id_v             = 1'b1;
         id_res.text_byte = c;
      end else if (c == jtl_pkg::CH_QUOTE) begin
         id_start = 1'b1;
         id_mode  = MODE_STR;
      end else if ((c == jtl_pkg::CH_T) || (c == jtl_pkg::CH_F) ||
                   (c == jtl_pkg::CH_N)) begin
         id_start = 1'b1;
         id_mode  = MODE_WORD;
         id_wlen  = 3'd1;
         id_cand  = (c == jtl_pkg::CH_T) ? 3'b001 :
                    (c == jtl_pkg::CH_F) ? 3'b010 : 3'b100;
      end else begin
         id_v = 1'b1;
         unique case (c)
            jtl_pkg::CH_LBRACE:   id_res.token_kind = jtl_pkg::KIND_LBRACE;
            jtl_pkg::CH_RBRACE:   id_res.token_kind = jtl_pkg::KIND_RBRACE;
            jtl_pkg::CH_LBRACKET: id_res.token_kind = jtl_pkg::KIND_LBRACKET;
            jtl_pkg::CH_RBRACKET: id_res.token_kind = jtl_pkg::KIND_RBRACKET;
            jtl_pkg::CH_COLON:    id_res.token_kind = jtl_pkg::KIND_COLON;
            jtl_pkg::CH_COMMA:    id_res.token_kind = jtl_pkg::KIND_COMMA;
            default: begin
               id_mode           = MODE_ERR;
               id_res.token_kind = jtl_pkg::KIND_ERROR;
               id_res.error_code = jtl_pkg::ERR_ILLEGAL_CH;
            end
         endcase
      end
   end

   always_comb begin
      wk_legal = 1'b1;
      priority if (cand_ff[0] && (wlen_ff == 3'd4)) begin
         wk_kind = jtl_pkg::KIND_TRUE;
      end else if (cand_ff[1] && (wlen_ff == 3'd5)) begin
         wk_kind = jtl_pkg::KIND_FALSE;
      end else if (cand_ff[2] && (wlen_ff == 3'd4)) begin
         wk_kind = jtl_pkg::KIND_NULL;
      end else begin
         wk_kind  = jtl_pkg::KIND_ERROR;
         wk_legal = 1'b0;
      end
   end

   // one pass over the item: next state and up to two events
   always_comb begin
      mode_in       = mode_ff;
      dot_in        = dot_ff;
      prev_digit_in = prev_digit_ff;
      wlen_in       = wlen_ff;
      cand_in       = cand_ff;
      offset_in     = (offset_ff != '1) ? offset_ff + 1'b1 : offset_ff;
      use_idle      = 1'b0;
      idle_slot1    = 1'b0;
      r0_v          = 1'b0;
      r1_v          = 1'b0;
      r0.token_kind  = jtl_pkg::KIND_TEXT;
      r0.text_byte   = 8'd0;
      r0.error_code  = jtl_pkg::ERR_NONE;
      r0.position    = pos_now;
      r0.last_result = 1'b0;
      r1             = r0;
      r1.token_kind  = jtl_pkg::KIND_END;

      if (req_action == jtl_pkg::ACT_END) begin
         r0_v = 1'b1;
         unique case (mode_ff)
            MODE_NUM: begin
               r0.token_kind = dot_ff ? jtl_pkg::KIND_FLOAT : jtl_pkg::KIND_INT;
               r1_v          = 1'b1;
            end
            MODE_WORD: begin
               r0.token_kind = wk_kind;
               r0.error_code = wk_legal ? jtl_pkg::ERR_NONE : jtl_pkg::ERR_IDENT;
               r1_v          = 1'b1;
            end
            MODE_STR: begin
               r0.token_kind = jtl_pkg::KIND_ERROR;
               r0.error_code = jtl_pkg::ERR_LINE_END;
               r1_v          = 1'b1;
            end
            default: begin
               r0.token_kind = jtl_pkg::KIND_END;
            end
         endcase
         mode_in       = MODE_IDLE;
         dot_in        = 1'b0;
         prev_digit_in = 1'b0;
         wlen_in       = 3'd0;
         cand_in       = 3'b111;
         offset_in     = '0;
      end else begin
         unique case (mode_ff)
            MODE_IDLE: begin
               use_idle = 1'b1;
            end
            MODE_NUM: begin
               r0_v = 1'b1;
               priority if (c_digit) begin
                  prev_digit_in = 1'b1;
                  r0.text_byte  = c;
               end else if (c == jtl_pkg::CH_DOT) begin
                  if (dot_ff || !prev_digit_ff) begin
                     mode_in       = MODE_ERR;
                     r0.token_kind = jtl_pkg::KIND_ERROR;
                     r0.error_code = jtl_pkg::ERR_NUMBER;
                  end else begin
                     dot_in        = 1'b1;
                     prev_digit_in = 1'b0;
                     r0.text_byte  = c;
                  end
               end else begin
                  r0.token_kind = dot_ff ? jtl_pkg::KIND_FLOAT : jtl_pkg::KIND_INT;
                  use_idle      = 1'b1;
                  idle_slot1    = 1'b1;
               end
            end
            MODE_STR: begin
               r0_v = 1'b1;
               priority if (c == jtl_pkg::CH_QUOTE) begin
                  mode_in       = MODE_IDLE;
                  r0.token_kind = jtl_pkg::KIND_STRING;
               end else if ((c == jtl_pkg::CH_LF) || (c == jtl_pkg::CH_CR)) begin
                  mode_in       = MODE_ERR;
                  r0.token_kind = jtl_pkg::KIND_ERROR;
                  r0.error_code = jtl_pkg::ERR_LINE_END;
               end else begin
                  r0.text_byte = c;
               end
            end
            MODE_WORD: begin
               if (c_lower) begin
                  if ((wlen_ff >= 3'd4) || (c != jtl_pkg::KW_TRUE[wlen_ff[1:0]]))
                     cand_in[0] = 1'b0;
                  if ((wlen_ff >= 3'd5) || (c != jtl_pkg::KW_FALSE[wlen_ff]))
                     cand_in[1] = 1'b0;
                  if ((wlen_ff >= 3'd4) || (c != jtl_pkg::KW_NULL[wlen_ff[1:0]]))
                     cand_in[2] = 1'b0;
                  if (wlen_ff != 3'd7)
                     wlen_in = wlen_ff + 3'd1;
               end else begin
                  r0_v          = 1'b1;
                  r0.token_kind = wk_kind;
                  if (wk_legal) begin
                     mode_in    = MODE_IDLE;
                     use_idle   = 1'b1;
                     idle_slot1 = 1'b1;
                  end else begin
                     // the terminator is swallowed by the error state
                     mode_in       = MODE_ERR;
                     r0.error_code = jtl_pkg::ERR_IDENT;
                  end
               end
            end
            MODE_ERR: begin
               mode_in = MODE_ERR;
            end
            default: begin
               mode_in = MODE_ERR;
            end
         endcase

         if (use_idle) begin
            mode_in = id_mode;
            if (id_start) begin
               dot_in        = 1'b0;
               prev_digit_in = id_digit;
               wlen_in       = id_wlen;
               cand_in       = id_cand;
            end
            if (idle_slot1) begin
               r1_v = id_v;
               r1   = id_res;
            end else begin
               r0_v = id_v;
               r0   = id_res;
            end
         end
      end
   end

   always_comb begin
      r0_q             = r0;
      r1_q             = r1;
      r0_q.last_result = !r1_v;
      r1_q.last_result = 1'b1;
   end

   assign push_n = accept ? ({1'b0, r0_v} + {1'b0, r1_v}) : 2'd0;

   assign wr_ptr_in = wr_ptr_ff + jtl_pkg::FIFO_AW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + jtl_pkg::FIFO_AW'(pop);
   assign count_in  = count_ff + jtl_pkg::FIFO_CW'(push_n) - jtl_pkg::FIFO_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         dot_ff        <= 1'b0;
         prev_digit_ff <= 1'b0;
         wlen_ff       <= 3'd0;
         cand_ff       <= 3'b111;
         offset_ff     <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            dot_ff        <= dot_in;
            prev_digit_ff <= prev_digit_in;
            wlen_ff       <= wlen_in;
            cand_ff       <= cand_in;
            offset_ff     <= offset_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && r0_v)
         fifo_ff[wr_ptr_ff] <= r0_q;
      if (accept && r1_v)
         fifo_ff[wr_ptr_ff + jtl_pkg::FIFO_AW'(1)] <= r1_q;
   end

   assign req_ready       = count_ff <= jtl_pkg::FIFO_CW'(jtl_pkg::FIFO_DEPTH - 2);
   assign rsp_valid       = count_ff != '0;
   assign rsp_token_kind  = fifo_ff[rd_ptr_ff].token_kind;
   assign rsp_text_byte   = fifo_ff[rd_ptr_ff].text_byte;
   assign rsp_error_code  = fifo_ff[rd_ptr_ff].error_code;
   assign rsp_position    = fifo_ff[rd_ptr_ff].position;
   assign rsp_last_result = fifo_ff[rd_ptr_ff].last_result;

endmodule

/* rtl/jtl_checker.sv */
// ---------------------------------------------------------------------------
// JSON token lexer checker
// Port-level assertions on the result channel and req_ready, bound to the lexer module.
// ---------------------------------------------------------------------------
`include "json_token_lexer_assert.svh"

module jtl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_token_kind,
   input logic [7:0]  rsp_text_byte,
   input logic [2:0]  rsp_error_code,
   input logic [23:0] rsp_position,
   input logic        rsp_last_result
);

   logic [39:0] rsp_item;
   logic        kind_is_error;
   logic        code_set;

   assign rsp_item      = {rsp_token_kind, rsp_text_byte, rsp_error_code, rsp_position,
                           rsp_last_result};
   assign kind_is_error = rsp_token_kind == jtl_pkg::KIND_ERROR;
   assign code_set      = rsp_error_code != jtl_pkg::ERR_NONE;

   `JTL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item), "stalled rsp item changed")

   `JTL_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready, "queue not empty after reset")

   `JTL_ASSERT_SAME(a_code_iff_error, clock, reset, rsp_valid, kind_is_error == code_set, "error code does not match kind")

   `JTL_ASSERT_SAME(a_text_only_bytes, clock, reset, rsp_valid && (rsp_token_kind != jtl_pkg::KIND_TEXT), rsp_text_byte == 8'd0, "text byte set on a token")

   `JTL_ASSERT_SAME(a_end_is_last, clock, reset, rsp_valid && (rsp_token_kind == jtl_pkg::KIND_END), rsp_last_result, "end token not marked last")

endmodule

bind json_token_lexer jtl_checker u_jtl_checker (.*);

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// JSON token lexer testbench
// Drives byte and end-of-input items into the lexer and checks every token
// event against a predictor of the lexer state machine. A short directed
// sequence is followed by random JSON fragments over four idling phases.
// ---------------------------------------------------------------------------
module tb;

   typedef enum logic [2:0] {
      LEX_IDLE, LEX_NUMBER, LEX_STRING, LEX_WORD, LEX_ERROR
   } lex_mode_type;

   typedef struct packed {
      logic       action;
      logic [7:0] ch;
   } text_item_type;

   // punctuation first, whitespace after
   localparam logic [7:0] SEPARATORS [12] = '{
      jtl_pkg::CH_LBRACE, jtl_pkg::CH_RBRACE, jtl_pkg::CH_LBRACKET,
      jtl_pkg::CH_RBRACKET, jtl_pkg::CH_COLON, jtl_pkg::CH_COMMA,
      jtl_pkg::CH_SPACE, jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_VT,
      jtl_pkg::CH_FF, jtl_pkg::CH_CR};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = jtl_pkg::ACT_BYTE;
   logic [7:0]  req_char_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [7:0]  rsp_text_byte;
   logic [2:0]  rsp_error_code;
   logic [23:0] rsp_position;
   logic        rsp_last_result;

   text_item_type    text_items [$];
   jtl_pkg::rsp_type expected_tokens [$];
   int               items_sent = 0;
   int               items_taken = 0;
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;

   // predictor state
   lex_mode_type                      lex_mode;
   logic                              saw_dot;
   logic                              prev_digit;
   logic [2:0]                        word_len;
   logic [2:0]                        word_cand;
   logic [jtl_pkg::POSITION_BITS-1:0] byte_offset;

   json_token_lexer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_char_byte   (req_char_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_position    (rsp_position),
      .rsp_last_result (rsp_last_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- predictor ----------------

   function automatic void add_token(logic [3:0] kind, logic [7:0] text,
                                     logic [2:0] code,
                                     logic [jtl_pkg::POSITION_BITS-1:0] pos);
      jtl_pkg::rsp_type t;
      t.token_kind  = kind;
      t.text_byte   = text;
      t.error_code  = code;
      t.position    = pos[jtl_pkg::POS_OUT_BITS-1:0];
      t.last_result = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == jtl_pkg::CH_SPACE || c == jtl_pkg::CH_TAB || c == jtl_pkg::CH_LF ||
             c == jtl_pkg::CH_VT || c == jtl_pkg::CH_FF || c == jtl_pkg::CH_CR;
   endfunction

   function automatic void clear_token();
      saw_dot    = 1'b0;
      prev_digit = 1'b0;
      word_len   = 3'd0;
      word_cand  = 3'b111;
   endfunction

   function automatic void lex_reset();
      lex_mode    = LEX_IDLE;
      clear_token();
      byte_offset = '0;
   endfunction

   function automatic void start_token(logic [7:0] c,
                                       logic [jtl_pkg::POSITION_BITS-1:0] pos);
      logic [3:0] kind;
      if (is_digit(c) || c == jtl_pkg::CH_MINUS) begin
         clear_token();
         lex_mode   = LEX_NUMBER;
         prev_digit = is_digit(c);
         add_token(jtl_pkg::KIND_TEXT, c, jtl_pkg::ERR_NONE, pos);
      end else if (c == jtl_pkg::CH_QUOTE) begin
         clear_token();
         lex_mode = LEX_STRING;
      end else if (c == jtl_pkg::CH_T || c == jtl_pkg::CH_F || c == jtl_pkg::CH_N) begin
         clear_token();
         lex_mode  = LEX_WORD;
         word_len  = 3'd1;
         word_cand = (c == jtl_pkg::CH_T) ? 3'b001 : (c == jtl_pkg::CH_F) ? 3'b010 : 3'b100;
      end else if (!is_space(c)) begin
         case (c)
            jtl_pkg::CH_LBRACE:   kind = jtl_pkg::KIND_LBRACE;
            jtl_pkg::CH_RBRACE:   kind = jtl_pkg::KIND_RBRACE;
            jtl_pkg::CH_LBRACKET: kind = jtl_pkg::KIND_LBRACKET;
            jtl_pkg::CH_RBRACKET: kind = jtl_pkg::KIND_RBRACKET;
            jtl_pkg::CH_COLON:    kind = jtl_pkg::KIND_COLON;
            jtl_pkg::CH_COMMA:    kind = jtl_pkg::KIND_COMMA;
            default:              kind = jtl_pkg::KIND_ERROR;
         endcase
         if (kind == jtl_pkg::KIND_ERROR) begin
            lex_mode = LEX_ERROR;
            add_token(jtl_pkg::KIND_ERROR, 8'h00, jtl_pkg::ERR_ILLEGAL_CH, pos);
         end else begin
            add_token(kind, 8'h00, jtl_pkg::ERR_NONE, pos);
         end
      end
   endfunction

   function automatic bit finish_word(logic [jtl_pkg::POSITION_BITS-1:0] pos);
      bit ok;
      ok = 1'b1;
      if (word_cand[0] && word_len == 3'd4) begin
         add_token(jtl_pkg::KIND_TRUE, 8'h00, jtl_pkg::ERR_NONE, pos);
      end else if (word_cand[1] && word_len == 3'd5) begin
         add_token(jtl_pkg::KIND_FALSE, 8'h00, jtl_pkg::ERR_NONE, pos);
      end else if (word_cand[2] && word_len == 3'd4) begin
         add_token(jtl_pkg::KIND_NULL, 8'h00, jtl_pkg::ERR_NONE, pos);
      end else begin
         add_token(jtl_pkg::KIND_ERROR, 8'h00, jtl_pkg::ERR_IDENT, pos);
         ok = 1'b0;
      end
      lex_mode = ok ? LEX_IDLE : LEX_ERROR;
      return ok;
   endfunction

   function automatic void word_letter(logic [7:0] c);
      if (word_len >= 3'd4 || jtl_pkg::KW_TRUE[word_len[1:0]] != c) word_cand[0] = 1'b0;
      if (word_len >= 3'd5) word_cand[1] = 1'b0;
      else if (jtl_pkg::KW_FALSE[word_len] != c) word_cand[1] = 1'b0;
      if (word_len >= 3'd4 || jtl_pkg::KW_NULL[word_len[1:0]] != c) word_cand[2] = 1'b0;
      if (word_len != 3'd7) word_len = word_len + 3'd1;
   endfunction

   function automatic void lex_step(logic act, logic [7:0] c);
      int                                first;
      logic [jtl_pkg::POSITION_BITS-1:0] pos;
      first = expected_tokens.size();
      pos   = byte_offset;
      if (act == jtl_pkg::ACT_END) begin
         case (lex_mode)
            LEX_NUMBER: add_token(saw_dot ? jtl_pkg::KIND_FLOAT : jtl_pkg::KIND_INT, 8'h00,
                                  jtl_pkg::ERR_NONE, pos);
            LEX_WORD:   void'(finish_word(pos));
            LEX_STRING: add_token(jtl_pkg::KIND_ERROR, 8'h00, jtl_pkg::ERR_LINE_END, pos);
            default:    ;
         endcase
         add_token(jtl_pkg::KIND_END, 8'h00, jtl_pkg::ERR_NONE, pos);
         lex_reset();
      end else begin
         case (lex_mode)
            LEX_NUMBER: begin
               if (is_digit(c)) begin
                  prev_digit = 1'b1;
                  add_token(jtl_pkg::KIND_TEXT, c, jtl_pkg::ERR_NONE, pos);
               end else if (c == jtl_pkg::CH_DOT) begin
                  if (saw_dot || !prev_digit) begin
                     lex_mode = LEX_ERROR;
                     add_token(jtl_pkg::KIND_ERROR, 8'h00, jtl_pkg::ERR_NUMBER, pos);
                  end else begin
                     saw_dot    = 1'b1;
                     prev_digit = 1'b0;
                     add_token(jtl_pkg::KIND_TEXT, c, jtl_pkg::ERR_NONE, pos);
                  end
               end else begin
                  // terminator is then lexed afresh, possibly a second token
                  add_token(saw_dot ? jtl_pkg::KIND_FLOAT : jtl_pkg::KIND_INT, 8'h00,
                            jtl_pkg::ERR_NONE, pos);
                  lex_mode = LEX_IDLE;
                  start_token(c, pos);
               end
            end
            LEX_STRING: begin
               if (c == jtl_pkg::CH_QUOTE) begin
                  lex_mode = LEX_IDLE;
                  add_token(jtl_pkg::KIND_STRING, 8'h00, jtl_pkg::ERR_NONE, pos);
               end else if (c == jtl_pkg::CH_LF || c == jtl_pkg::CH_CR) begin
                  lex_mode = LEX_ERROR;
                  add_token(jtl_pkg::KIND_ERROR, 8'h00, jtl_pkg::ERR_LINE_END, pos);
               end else begin
                  add_token(jtl_pkg::KIND_TEXT, c, jtl_pkg::ERR_NONE, pos);
               end
            end
            LEX_WORD: begin
               if (c >= "a" && c <= "z") word_letter(c);
               else if (finish_word(pos)) start_token(c, pos);
            end
            LEX_IDLE: start_token(c, pos);
            default:  ;
         endcase
         if (byte_offset != '1) byte_offset = byte_offset + 1'b1;
      end
      if (expected_tokens.size() > first)
         expected_tokens[expected_tokens.size() - 1].last_result = 1'b1;
   endfunction

   // ---------------- driver and monitor ----------------

   always @(posedge clock) begin : driver
      text_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         lex_reset();
      end else begin
         if (req_valid && req_ready) begin
            lex_step(req_action, req_char_byte);
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            if (text_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = text_items.pop_front();
               req_valid     <= 1'b1;
               req_action    <= nxt.action;
               req_char_byte <= nxt.ch;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      jtl_pkg::rsp_type got;
      jtl_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.token_kind  = rsp_token_kind;
            got.text_byte   = rsp_text_byte;
            got.error_code  = rsp_error_code;
            got.position    = rsp_position;
            got.last_result = rsp_last_result;
            if (expected_tokens.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected token: kind %0d byte %02h err %0d pos %0d last %0b",
                           got.token_kind, got.text_byte, got.error_code, got.position,
                           got.last_result);
               mismatch_count++;
            end else begin
               want = expected_tokens.pop_front();
               if (got.token_kind !== want.token_kind || got.text_byte !== want.text_byte ||
                   got.error_code !== want.error_code || got.position !== want.position ||
                   got.last_result !== want.last_result) begin
                  if (mismatch_count < 10)
                     $display({"token mismatch: expected kind %0d byte %02h err %0d pos %0d",
                               " last %0b, got kind %0d byte %02h err %0d pos %0d last %0b"},
                              want.token_kind, want.text_byte, want.error_code,
                              want.position, want.last_result, got.token_kind,
                              got.text_byte, got.error_code, got.position,
                              got.last_result);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------- stimulus ----------------

   function automatic void push_item(logic act, logic [7:0] c);
      text_item_type it;
      it.action = act;
      it.ch     = c;
      text_items.insert(text_items.size(), it);
      items_sent++;
   endfunction

   function automatic void push_byte(logic [7:0] c);
      push_item(jtl_pkg::ACT_BYTE, c);
   endfunction

   function automatic void push_end();
      push_item(jtl_pkg::ACT_END, 8'($urandom_range(255)));
   endfunction

   function automatic void push_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic void push_sep();
      if ($urandom_range(3) != 0) push_byte(SEPARATORS[$urandom_range(11)]);
   endfunction

   task automatic set_idle(int send_pct, int recv_pct);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // sender holds off until every item is taken and every token has come
   task automatic wait_drained();
      @(negedge clock);
      while (items_taken != items_sent || expected_tokens.size() != 0)
         @(negedge clock);
   endtask

   // mostly well-formed fragments with random content, some noise
   function automatic void fill_phase(int count);
      int    stop_at;
      int    r;
      int    n;
      int    i;
      string kw;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 22) begin
            if ($urandom_range(3) == 0) push_byte(jtl_pkg::CH_MINUS);
            repeat ($urandom_range(4, 1)) push_byte(8'("0" + $urandom_range(9)));
            if ($urandom_range(2) == 0) begin
               push_byte(jtl_pkg::CH_DOT);
               repeat ($urandom_range(3)) push_byte(8'("0" + $urandom_range(9)));
               if ($urandom_range(9) == 0) push_byte(jtl_pkg::CH_DOT);
            end
            push_sep();
         end else if (r < 42) begin
            push_byte(jtl_pkg::CH_QUOTE);
            repeat ($urandom_range(5)) begin
               if ($urandom_range(7) == 0) push_byte(8'($urandom_range(255)));
               else push_byte(8'($urandom_range(126, 35)));
            end
            if ($urandom_range(9) != 0) push_byte(jtl_pkg::CH_QUOTE);
            push_sep();
         end else if (r < 60) begin
            case ($urandom_range(2))
               0:       kw = "true";
               1:       kw = "false";
               default: kw = "null";
            endcase
            n = kw.len();
            if ($urandom_range(5) == 0) n = $urandom_range(n - 1, 1);
            for (i = 0; i < n; i++) push_byte(kw[i]);
            if ($urandom_range(7) == 0) push_byte(8'($urandom_range("z", "a")));
            push_sep();
         end else if (r < 82) begin
            push_byte(SEPARATORS[$urandom_range(5)]);
         end else if (r < 90) begin
            push_byte(SEPARATORS[$urandom_range(11, 6)]);
         end else if (r < 96) begin
            push_byte(8'($urandom_range(255)));
         end else begin
            push_end();
         end
      end
      push_end();
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_idle(0, 0);
      // punctuation, int ended by bracket, float ended by comma, string
      push_text("{\"x\":-1.5,[7]}");
      push_end();
      // bad keyword swallows its terminator; error holds until the end item
      push_text("tru}");
      push_byte(8'h00);
      push_end();
      // line end inside a string, then a high byte while in error
      push_byte(jtl_pkg::CH_QUOTE);
      push_byte(jtl_pkg::CH_LF);
      push_byte(8'hFF);
      push_end();
      // keyword finished by end of input
      push_text("null");
      push_end();
      fill_phase(430);
      wait_drained();

      set_idle(47, 0);
      fill_phase(430);
      wait_drained();

      set_idle(0, 47);
      fill_phase(430);
      wait_drained();

      set_idle(6, 6);
      fill_phase(430);
      wait_drained();

      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
